[hw/rtl/assert_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers. Define NO_ASSERTIONS to compile them away.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
// Checked on every rising edge of clk outside reset.
`define TPT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked on every rising edge of clk, reset included.
`define TPT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TPT_ASSERT(lbl, prop, msg)
`define TPT_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

[hw/rtl/tpt_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// TLB page table translator package
// Widths, result codes and the structs passed between the translator parts.
// ---------------------------------------------------------------------------
package tpt_pkg;

  // Address split and table sizes.
  localparam int ADDR_BITS     = 16;
  localparam int OFFSET_BITS   = 8;
  localparam int PAGE_BITS     = 8;
  localparam int FRAME_BITS    = 8;
  localparam int PAGE_COUNT    = 256;
  localparam int FRAME_COUNT   = 256;
  localparam int TLB_DEPTH_DEF = 16;

  // Result codes.
  typedef enum logic [1:0] {
    TS_TLB_HIT  = 2'd0,
    TS_PT_HIT   = 2'd1,
    TS_ALLOC    = 2'd2,
    TS_NO_FRAME = 2'd3
  } tpt_status_t;

  // One page table entry: valid flag over the frame number.
  typedef struct packed {
    logic                  valid;
    logic [FRAME_BITS-1:0] frame;
  } tpt_pte_t;

  // Access request to the page table memory.
  typedef struct packed {
    logic                 rd_en;
    logic [PAGE_BITS-1:0] rd_page;
    logic                 wr_en;
    logic [PAGE_BITS-1:0] wr_page;
    tpt_pte_t             wr_entry;
  } tpt_pt_req_t;

  // TLB fill request.
  typedef struct packed {
    logic                  en;
    logic [PAGE_BITS-1:0]  page;
    logic [FRAME_BITS-1:0] frame;
  } tpt_fill_t;

  // TLB lookup answer.
  typedef struct packed {
    logic                  hit;
    logic [FRAME_BITS-1:0] frame;
  } tpt_lookup_t;

endpackage

[hw/rtl/tpt_if.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// TLB page table translator channels
// Valid/ready channels for logical addresses in and translations out.
// ---------------------------------------------------------------------------
interface tpt_in_if
  import tpt_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic [ADDR_BITS-1:0] logical_address;

  modport source (output valid, output logical_address, input ready);
  modport sink   (input valid, input logical_address, output ready);
endinterface

interface tpt_out_if
  import tpt_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic [1:0]            status;
  logic [PAGE_BITS-1:0]  page_number;
  logic [FRAME_BITS-1:0] frame_number;
  logic [ADDR_BITS-1:0]  physical_address;

  modport source (output valid, output status, output page_number, output frame_number,
                  output physical_address, input ready);
  modport sink   (input valid, input status, input page_number, input frame_number,
                  input physical_address, output ready);
endinterface

[hw/rtl/tpt_page_table.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Page table memory
// Single-port-write, registered-read page table with a clearing sweep after
// reset that marks every entry invalid.
// ---------------------------------------------------------------------------
module tpt_page_table
  import tpt_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  tpt_pt_req_t req,
  output tpt_pte_t    rd_entry,
  output logic        busy
);

  tpt_pte_t             mem [PAGE_COUNT];
  tpt_pte_t             rd_entry_r;
  logic                 clearing_r;
  logic [PAGE_BITS-1:0] clr_idx_r;

  // Clearing sweep: one entry per cycle after reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_idx_r  <= '0;
    end else if (clearing_r) begin
      clr_idx_r <= clr_idx_r + 1'b1;
      if (clr_idx_r == PAGE_BITS'(PAGE_COUNT - 1)) begin
        clearing_r <= 1'b0;
      end
    end
  end

  // Write port, shared between the sweep and the translator.
  always_ff @(posedge clk) begin
    if (clearing_r) begin
      mem[clr_idx_r] <= '0;
    end else if (req.wr_en) begin
      mem[req.wr_page] <= req.wr_entry;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_entry_r <= mem[req.rd_page];
    end
  end

  assign rd_entry = rd_entry_r;
  assign busy     = clearing_r;

endmodule

[hw/rtl/tpt_tlb.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// TLB
// Fully associative TLB with a parallel tag compare and FIFO replacement.
// ---------------------------------------------------------------------------
module tpt_tlb
  import tpt_pkg::*;
#(
  parameter int TLB_DEPTH = TLB_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [PAGE_BITS-1:0] lookup_page,
  output tpt_lookup_t          lookup,
  input  tpt_fill_t            fill
);

  localparam int PTR_W = $clog2(TLB_DEPTH);

  logic [PAGE_BITS-1:0]  tag_r   [TLB_DEPTH];
  logic [FRAME_BITS-1:0] frame_r [TLB_DEPTH];
  logic [TLB_DEPTH-1:0]  valid_r;
  logic [PTR_W-1:0]      fill_ptr_r;
  logic [PTR_W-1:0]      fill_ptr_nxt;

  // Parallel compare; the lowest matching index wins.
  always_comb begin
    lookup = '0;
    for (int i = TLB_DEPTH - 1; i >= 0; i--) begin
      if (valid_r[i] && (tag_r[i] == lookup_page)) begin
        lookup.hit   = 1'b1;
        lookup.frame = frame_r[i];
      end
    end
  end

  // Fill pointer wraps after the last slot.
  always_comb begin
    if (fill_ptr_r == PTR_W'(TLB_DEPTH - 1)) begin
      fill_ptr_nxt = '0;
    end else begin
      fill_ptr_nxt = fill_ptr_r + 1'b1;
    end
  end

  // Valid bits and fill pointer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      fill_ptr_r <= '0;
    end else if (fill.en) begin
      valid_r[fill_ptr_r] <= 1'b1;
      fill_ptr_r          <= fill_ptr_nxt;
    end
  end

  // Tag and frame payload.
  always_ff @(posedge clk) begin
    if (fill.en) begin
      tag_r[fill_ptr_r]   <= fill.page;
      frame_r[fill_ptr_r] <= fill.frame;
    end
  end

endmodule

[hw/rtl/tlb_page_table_translator.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// TLB page table translator
// Translates 16-bit logical addresses through a FIFO-filled TLB and a page
// table, allocating frames on demand when a page faults.
//
//   Channel  Dir  Beat
//   in_ch    in   logical_address
//   out_ch   out  status, page_number, frame_number, physical_address
//
// An address is handled in order: the accept cycle reads the page table memory,
// then the lookup state compares the TLB, decides and writes the page table back.
// After reset a clearing sweep invalidates all PAGE_COUNT (256) page table
// entries; no beat is accepted during it.
// A waiting result is held in an output register; if it is not taken, the
// decision cycle of the next address waits until the register is free.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module tlb_page_table_translator
  import tpt_pkg::*;
#(
  parameter int TLB_DEPTH = TLB_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  tpt_in_if.sink     in_ch,
  tpt_out_if.source  out_ch
);

  typedef enum logic [2:0] {
    ST_CLEAR = 3'b001,
    ST_IDLE  = 3'b010,
    ST_LOOK  = 3'b100
  } state_t;

  state_t                  state_r, state_nxt;
  logic [PAGE_BITS-1:0]    page_r;
  logic [OFFSET_BITS-1:0]  offset_r;
  logic [FRAME_BITS-1:0]   next_free_r;
  logic                    exhausted_r;

  logic                    out_valid_r;
  tpt_status_t             out_status_r;
  logic [PAGE_BITS-1:0]    out_page_r;
  logic [FRAME_BITS-1:0]   out_frame_r;
  logic [ADDR_BITS-1:0]    out_paddr_r;

  logic                    in_fire;
  logic                    out_slot_free;
  logic                    commit;
  tpt_pt_req_t             pt_req;
  tpt_pte_t                pt_entry;
  logic                    pt_busy;
  tpt_lookup_t             tlb_res;
  tpt_fill_t               tlb_fill;
  tpt_status_t             res_status;
  logic [FRAME_BITS-1:0]   res_frame;
  logic [ADDR_BITS-1:0]    res_paddr;
  logic                    alloc;

  // Handshake.
  assign in_ch.ready   = (state_r == ST_IDLE);
  assign in_fire       = in_ch.valid && in_ch.ready;
  assign out_slot_free = !out_valid_r || out_ch.ready;
  assign commit        = (state_r == ST_LOOK) && out_slot_free;

  tpt_page_table u_pt (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (pt_req),
    .rd_entry (pt_entry),
    .busy     (pt_busy)
  );

  tpt_tlb #(
    .TLB_DEPTH (TLB_DEPTH)
  ) u_tlb (
    .clk         (clk),
    .rst_n       (rst_n),
    .lookup_page (page_r),
    .lookup      (tlb_res),
    .fill        (tlb_fill)
  );

  // Translation decision for the held address.
  always_comb begin
    res_status = TS_NO_FRAME;
    res_frame  = '0;
    alloc      = 1'b0;
    if (tlb_res.hit) begin
      res_status = TS_TLB_HIT;
      res_frame  = tlb_res.frame;
    end else if (pt_entry.valid) begin
      res_status = TS_PT_HIT;
      res_frame  = pt_entry.frame;
    end else if (!exhausted_r) begin
      res_status = TS_ALLOC;
      res_frame  = next_free_r;
      alloc      = 1'b1;
    end
    if (res_status == TS_NO_FRAME) begin
      res_paddr = '0;
    end else begin
      res_paddr = {res_frame, offset_r};
    end
  end

  // Page table read on accept, write back on allocation.
  always_comb begin
    pt_req                = '0;
    pt_req.rd_en          = in_fire;
    pt_req.rd_page        = in_ch.logical_address[ADDR_BITS-1:OFFSET_BITS];
    pt_req.wr_en          = commit && alloc;
    pt_req.wr_page        = page_r;
    pt_req.wr_entry.valid = 1'b1;
    pt_req.wr_entry.frame = next_free_r;
  end

  // TLB fill on a page table hit or an allocation.
  always_comb begin
    tlb_fill.en    = commit && !tlb_res.hit && (pt_entry.valid || !exhausted_r);
    tlb_fill.page  = page_r;
    tlb_fill.frame = res_frame;
  end

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (!pt_busy) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_fire) begin
          state_nxt = ST_LOOK;
        end
      end
      ST_LOOK: begin
        if (commit) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Address capture.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      page_r   <= in_ch.logical_address[ADDR_BITS-1:OFFSET_BITS];
      offset_r <= in_ch.logical_address[OFFSET_BITS-1:0];
    end
  end

  // Free frame allocator.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      next_free_r <= '0;
      exhausted_r <= 1'b0;
    end else if (commit && alloc) begin
      if (next_free_r == FRAME_BITS'(FRAME_COUNT - 1)) begin
        exhausted_r <= 1'b1;
      end else begin
        next_free_r <= next_free_r + 1'b1;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (commit) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_status_r <= res_status;
      out_page_r   <= page_r;
      out_frame_r  <= res_frame;
      out_paddr_r  <= res_paddr;
    end
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.status           = out_status_r;
  assign out_ch.page_number      = out_page_r;
  assign out_ch.frame_number     = out_frame_r;
  assign out_ch.physical_address = out_paddr_r;

  // Checks.
  `TPT_ASSERT_ALWAYS(a_reset_clears, !rst_n |=> state_r == ST_CLEAR, "reset must start the sweep")
  `TPT_ASSERT(a_accept_looks, in_fire |=> state_r == ST_LOOK, "accepted beat not looked up")
  `TPT_ASSERT(a_stall_holds, state_r == ST_LOOK && !out_slot_free |=> state_r == ST_LOOK && $stable(page_r), "stalled lookup lost its address")
  `TPT_ASSERT(a_exhaust_sticky, exhausted_r |=> exhausted_r, "frame exhaustion cleared")
  `TPT_ASSERT(a_noframe_zero, out_valid_r && out_status_r == TS_NO_FRAME |-> out_paddr_r == '0 && out_frame_r == '0, "no-frame result carries an address")

endmodule

[test/tlb_page_table_translator_tb.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// TLB page table translator testbench
// Sends logical addresses through the translator and checks every returned
// translation against a typed-in value or an in-bench model of the TLB, the
// page table and the frame allocator. Directed addresses from a short table
// come first, then random ones biased toward recent, mapped and fresh pages.
// ---------------------------------------------------------------------------
module tlb_page_table_translator_tb;
  import tpt_pkg::*;

  localparam int TLB_SLOTS    = TLB_DEPTH_DEF;
  localparam int RANDOM_ITEMS = 950;
  localparam int CYCLE_LIMIT  = 300000;
  localparam int HOLD_AT      = 150;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_AT     = 500;

  // One translation as the block reports it.
  typedef struct {
    tpt_status_t     status;
    logic [7:0]      page;
    logic [7:0]      frame;
    logic [15:0]     paddr;
  } xlat_t;

  // One row of the directed table; known marks a typed-in expectation.
  typedef struct packed {
    logic [15:0] addr;
    logic        known;
    tpt_status_t status;
    logic [7:0]  page;
    logic [7:0]  frame;
    logic [15:0] paddr;
  } addr_row_t;

  localparam int DIRECTED_ROWS = 23;
  localparam addr_row_t DIRECTED [DIRECTED_ROWS] = '{
    '{16'h0000, 1'b1, TS_ALLOC,   8'h00, 8'h00, 16'h0000},
    '{16'h00FF, 1'b1, TS_TLB_HIT, 8'h00, 8'h00, 16'h00FF},
    '{16'hFFFF, 1'b1, TS_ALLOC,   8'hFF, 8'h01, 16'h01FF},
    '{16'hFF00, 1'b1, TS_TLB_HIT, 8'hFF, 8'h01, 16'h0100},
    '{16'h0180, 1'b1, TS_ALLOC,   8'h01, 8'h02, 16'h0280},
    '{16'h0255, 1'b0, TS_TLB_HIT, 8'h00, 8'h00, 16'h0000},
    '{16'h03AA, 1'b0, TS_TLB_HIT, 8'h00, 8'h00, 16'h0000},
    '{16'h0455, 1'b0, TS_TLB_HIT, 8'h00, 8'h00, 16'h0000},
    '{16'h05AA, 1'b0, TS_TLB_HIT, 8'h00, 8'h00, 16'h0000},
    '{16'h0601, 1'b0, TS_TLB_HIT, 8'h00, 8'h00, 16'h0000},
    '{16'h07FE, 1'b0, TS_TLB_HIT, 8'h00, 8'h00, 16'h0000},
    '{16'h0855, 1'b0, TS_TLB_HIT, 8'h00, 8'h00, 16'h0000},
    '{16'h09AA, 1'b0, TS_TLB_HIT, 8'h00, 8'h00, 16'h0000},
    '{16'h0A00, 1'b0, TS_TLB_HIT, 8'h00, 8'h00, 16'h0000},
    '{16'h0BFF, 1'b0, TS_TLB_HIT, 8'h00, 8'h00, 16'h0000},
    '{16'h0C55, 1'b0, TS_TLB_HIT, 8'h00, 8'h00, 16'h0000},
    '{16'h0DAA, 1'b0, TS_TLB_HIT, 8'h00, 8'h00, 16'h0000},
    '{16'h0E33, 1'b0, TS_TLB_HIT, 8'h00, 8'h00, 16'h0000},
    // Page 15 is the seventeenth fill and pushes page 0 out of the TLB.
    '{16'h0F7F, 1'b0, TS_TLB_HIT, 8'h00, 8'h00, 16'h0000},
    '{16'h0000, 1'b1, TS_PT_HIT,  8'h00, 8'h00, 16'h0000},
    '{16'hFFAA, 1'b1, TS_PT_HIT,  8'hFF, 8'h01, 16'h01AA},
    '{16'h0155, 1'b0, TS_TLB_HIT, 8'h00, 8'h00, 16'h0000},
    '{16'h0E33, 1'b0, TS_TLB_HIT, 8'h00, 8'h00, 16'h0000}
  };

  logic clk;
  logic rst_n;

  tpt_in_if  in_ch ();
  tpt_out_if out_ch ();

  tlb_page_table_translator dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Model state: TLB, page table and frame allocator.
  logic [7:0] tlb_tags   [TLB_SLOTS];
  logic [7:0] tlb_frames [TLB_SLOTS];
  bit         tlb_valids [TLB_SLOTS];
  tpt_pte_t   pte        [PAGE_COUNT];
  int         fill_slot;
  logic [7:0] free_frame;
  bit         out_of_frames;

  xlat_t      pending_xlats [$];
  logic [7:0] recent_pages  [$];
  int         mismatches;
  int         n_results;

  // 20 ns clock.
  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Translates one address and updates the model state.
  function automatic xlat_t translate(input logic [15:0] addr);
    xlat_t      r;
    logic [7:0] pg;
    bit         hit;
    pg       = addr[15:8];
    hit      = 1'b0;
    r.status = TS_NO_FRAME;
    r.page   = pg;
    r.frame  = 8'h00;
    r.paddr  = 16'h0000;
    // Lowest matching valid entry wins.
    for (int i = 0; i < TLB_SLOTS; i++) begin
      if (!hit && tlb_valids[i] && tlb_tags[i] == pg) begin
        hit      = 1'b1;
        r.frame  = tlb_frames[i];
        r.status = TS_TLB_HIT;
      end
    end
    if (!hit) begin
      if (pte[pg].valid) begin
        r.frame  = pte[pg].frame;
        r.status = TS_PT_HIT;
      end else if (!out_of_frames) begin
        r.frame  = free_frame;
        pte[pg]  = '{valid: 1'b1, frame: free_frame};
        r.status = TS_ALLOC;
        if (free_frame == 8'(FRAME_COUNT - 1)) out_of_frames = 1'b1;
        else free_frame++;
      end
      // A found translation goes into the FIFO slot.
      if (r.status != TS_NO_FRAME) begin
        tlb_tags[fill_slot]   = pg;
        tlb_frames[fill_slot] = r.frame;
        tlb_valids[fill_slot] = 1'b1;
        fill_slot             = (fill_slot + 1) % TLB_SLOTS;
      end
    end
    if (r.status != TS_NO_FRAME) r.paddr = {r.frame, addr[7:0]};
    return r;
  endfunction

  // Finds a page whose table entry has the wanted validity, from a random start.
  function automatic logic [7:0] pick_page(input bit want_valid);
    logic [7:0] start;
    logic [7:0] p;
    start = 8'($urandom_range(0, 255));
    for (int i = 0; i < PAGE_COUNT; i++) begin
      p = start + 8'(i);
      if (pte[p].valid == want_valid) return p;
    end
    return start;
  endfunction

  // Random address: mostly recent pages, mapped pages and fresh pages.
  function automatic logic [15:0] random_addr();
    int         pick;
    logic [7:0] pg;
    pick = $urandom_range(0, 99);
    if (pick < 35 && recent_pages.size() > 0)
      pg = recent_pages[$urandom_range(0, recent_pages.size() - 1)];
    else if (pick < 60)
      pg = pick_page(1'b1);
    else if (pick < 85)
      pg = pick_page(1'b0);
    else
      pg = 8'($urandom_range(0, 255));
    return {pg, 8'($urandom_range(0, 255))};
  endfunction

  task automatic check_field(input string fname, input int want, input int got);
    if (want != got) begin
      $error("%s mismatch: expected 0x%0h, actual 0x%0h", fname, want, got);
      mismatches++;
    end
  endtask

  // Offers one address after a gap and records the translation once accepted.
  task automatic send_addr(input logic [15:0] addr, input int gap, input bit known,
                           input xlat_t typed);
    xlat_t predicted;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid           <= 1'b1;
    in_ch.logical_address <= addr;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predicted = translate(addr);
    pending_xlats.push_back(known ? typed : predicted);
    recent_pages.push_back(addr[15:8]);
    if (recent_pages.size() > TLB_SLOTS) void'(recent_pages.pop_front());
  endtask

  // Timeout.
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("tb: failure");
    $finish;
  end

  // Result side: random stalls, one long hold-off, checks each beat.
  initial begin
    int    stall;
    bit    held;
    xlat_t want;
    held = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (n_results == HOLD_AT && !held) begin
        held = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      stall = ((n_results % 100) < 20) ? 0 : $urandom_range(0, 13);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
      n_results++;
      if (pending_xlats.size() == 0) begin
        $error("unexpected result beat: page 0x%0h", out_ch.page_number);
        mismatches++;
      end else begin
        want = pending_xlats.pop_front();
        check_field("status", int'(want.status), int'(out_ch.status));
        check_field("page_number", int'(want.page), int'(out_ch.page_number));
        check_field("frame_number", int'(want.frame), int'(out_ch.frame_number));
        check_field("physical_address", int'(want.paddr), int'(out_ch.physical_address));
      end
    end
  end

  // Reset, directed table, random addresses, drain and verdict.
  initial begin
    xlat_t typed;
    int    gap;
    in_ch.valid           <= 1'b0;
    in_ch.logical_address <= '0;
    out_ch.ready          <= 1'b0;
    rst_n                 <= 1'b0;
    mismatches    = 0;
    n_results     = 0;
    fill_slot     = 0;
    free_frame    = 8'h00;
    out_of_frames = 1'b0;
    for (int i = 0; i < TLB_SLOTS; i++) begin
      tlb_tags[i]   = 8'h00;
      tlb_frames[i] = 8'h00;
      tlb_valids[i] = 1'b0;
    end
    for (int i = 0; i < PAGE_COUNT; i++) pte[i] = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed table.
    for (int k = 0; k < DIRECTED_ROWS; k++) begin
      typed.status = DIRECTED[k].status;
      typed.page   = DIRECTED[k].page;
      typed.frame  = DIRECTED[k].frame;
      typed.paddr  = DIRECTED[k].paddr;
      gap = (k < 8) ? 0 : $urandom_range(0, 13);
      send_addr(DIRECTED[k].addr, gap, DIRECTED[k].known, typed);
    end

    // Random part, with one pause until all results are back.
    for (int k = 0; k < RANDOM_ITEMS; k++) begin
      if (k == DRAIN_AT) begin
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_xlats.size() != 0) @(posedge clk);
      end
      gap = ((k % 100) < 25) ? 0 : $urandom_range(0, 13);
      send_addr(random_addr(), gap, 1'b0, typed);
    end
    in_ch.valid <= 1'b0;

    while (pending_xlats.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
